// ----- rtl/pl0sm_pkg.sv -----
// Shared constants for the PL/0 stack machine step unit.
// No dependencies; used by the top level, its checker and the bench.
package pl0sm_pkg;

  // Sizes
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned STACK_DEPTH = 2048;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CODE_DEPTH  = 512;
  localparam int unsigned PC_W        = $clog2(CODE_DEPTH);
  localparam int unsigned LVL_W       = 3;
  localparam int unsigned OPND_W      = 16;
  localparam int unsigned IDX_W       = OPND_W + 1;
  localparam int unsigned DCNT_W      = $clog2(WORD_BITS);

  // Instruction codes
  localparam logic [3:0] OP_LIT  = 4'd1;
  localparam logic [3:0] OP_OPR  = 4'd2;
  localparam logic [3:0] OP_LOD  = 4'd3;
  localparam logic [3:0] OP_STO  = 4'd4;
  localparam logic [3:0] OP_CAL  = 4'd5;
  localparam logic [3:0] OP_INC  = 4'd6;
  localparam logic [3:0] OP_JMP  = 4'd7;
  localparam logic [3:0] OP_JPC  = 4'd8;
  localparam logic [3:0] OP_SIOA = 4'd9;
  localparam logic [3:0] OP_SIOC = 4'd11;

  // Operation numbers for OPR
  localparam logic [OPND_W-1:0] OPR_RET = 16'd0;
  localparam logic [OPND_W-1:0] OPR_NEG = 16'd1;
  localparam logic [OPND_W-1:0] OPR_ADD = 16'd2;
  localparam logic [OPND_W-1:0] OPR_SUB = 16'd3;
  localparam logic [OPND_W-1:0] OPR_MUL = 16'd4;
  localparam logic [OPND_W-1:0] OPR_DIV = 16'd5;
  localparam logic [OPND_W-1:0] OPR_ODD = 16'd6;
  localparam logic [OPND_W-1:0] OPR_MOD = 16'd7;
  localparam logic [OPND_W-1:0] OPR_EQL = 16'd8;
  localparam logic [OPND_W-1:0] OPR_NEQ = 16'd9;
  localparam logic [OPND_W-1:0] OPR_LSS = 16'd10;
  localparam logic [OPND_W-1:0] OPR_LEQ = 16'd11;
  localparam logic [OPND_W-1:0] OPR_GTR = 16'd12;
  localparam logic [OPND_W-1:0] OPR_GEQ = 16'd13;

  // I/O codes
  localparam logic [OPND_W-1:0] SIO_WRITE = 16'd1;
  localparam logic [OPND_W-1:0] SIO_READ  = 16'd2;
  localparam logic [OPND_W-1:0] SIO_HALT  = 16'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIVZ  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

endpackage

// ----- rtl/pl0sm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pl0sm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/pl0_stack_machine_step_unit.sv -----
// PL/0 stack machine: executes one instruction per request on a stack RAM.
// Depends on pl0sm_pkg and pl0sm_ram.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_stall_o   | opcode, level, operand, read_value
//   out     | output    | out_valid_o/out_stall_i | next_pc, stack_top, frame_base,
//           |           |                        | write_valid, write_value, halted, status
//
// A request walks the static links one hop at a time, writes the four frame
// words of a call through the single RAM write port and runs a divide or
// modulo through the radix-2 shared divider; operands come through the stack
// RAM read port, one word a cycle. After reset all 2048 stack RAM words are
// zeroed, one word a cycle, with in_stall_o high. A result waits in an output
// register, so a stall on the output holds back only the next result, not the next request.
module pl0_stack_machine_step_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [3:0]                           opcode_i,
  input  logic [pl0sm_pkg::LVL_W-1:0]          level_i,
  input  logic [pl0sm_pkg::OPND_W-1:0]         operand_i,
  input  logic signed [31:0]                   read_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [pl0sm_pkg::PC_W-1:0]           next_pc_o,
  output logic [pl0sm_pkg::ADDR_W-1:0]         stack_top_o,
  output logic [pl0sm_pkg::ADDR_W-1:0]         frame_base_o,
  output logic                                 write_valid_o,
  output logic signed [pl0sm_pkg::WORD_BITS-1:0] write_value_o,
  output logic                                 halted_o,
  output logic [1:0]                           status_o
);

  localparam int unsigned W  = pl0sm_pkg::WORD_BITS;
  localparam int unsigned AW = pl0sm_pkg::ADDR_W;
  localparam int unsigned PW = pl0sm_pkg::PC_W;
  localparam int unsigned MW = pl0sm_pkg::OPND_W;
  localparam int unsigned XW = pl0sm_pkg::IDX_W;
  localparam int unsigned DW = pl0sm_pkg::DCNT_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HOP   = 4'd2;
  localparam logic [3:0] S_HOPW  = 4'd3;
  localparam logic [3:0] S_RDA   = 4'd4;
  localparam logic [3:0] S_RDB   = 4'd5;
  localparam logic [3:0] S_RDC   = 4'd6;
  localparam logic [3:0] S_EXE   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DFIX  = 4'd9;
  localparam logic [3:0] S_WB    = 4'd10;
  localparam logic [3:0] S_CAL   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  // Control state
  logic [3:0]    state_q;
  logic [AW-1:0] clr_q;
  logic [AW-1:0] sp_q, bp_q;
  logic [PW-1:0] pc_q;
  logic          halt_q;
  logic [2:0]    hop_q;
  logic [1:0]    cal_q;
  logic [DW-1:0] dcnt_q;
  logic          err1_q, err2_q, wvalid_q;
  logic          out_valid_q;

  // Request and datapath registers
  logic [3:0]    op_q;
  logic [MW-1:0] m_q;
  logic [W-1:0]  rv_q, fb_q, opa_q, opb_q, res_q, wval_q;
  logic [W-1:0]  dq_q, dr_q, dv_q;
  logic          oob_a_q, oob_b_q;
  logic [PW-1:0] o_pc_q;
  logic [AW-1:0] o_sp_q, o_bp_q;
  logic          o_wv_q, o_halt_q;
  logic [W-1:0]  o_wval_q;
  logic [1:0]    o_st_q;

  // RAM port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [W-1:0]  ram_wdata, ram_rdata;

  // Decode of the held request
  logic is_opr, opr_ret, opr_un, opr_bin, opr_dm, is_sio, sio_wr, sio_rd, sio_halt;
  logic need_a, need_b, oob_a, oob_b;
  logic [AW-1:0] below, addr_a, addr_b;
  logic fb_ok;
  logic [AW:0]   hop_sum, ret4_sum, ret3_sum, cal_sum;
  logic [XW-1:0] lod_sum;
  logic hop_oob, lod_oob, cal_oob;
  logic accept, halted_now, out_free;

  assign is_opr   = (op_q == pl0sm_pkg::OP_OPR);
  assign opr_ret  = is_opr && (m_q == pl0sm_pkg::OPR_RET);
  assign opr_un   = is_opr && (m_q == pl0sm_pkg::OPR_NEG || m_q == pl0sm_pkg::OPR_ODD);
  assign opr_bin  = is_opr && (m_q >= pl0sm_pkg::OPR_ADD) && (m_q <= pl0sm_pkg::OPR_GEQ)
                    && (m_q != pl0sm_pkg::OPR_ODD);
  assign opr_dm   = is_opr && (m_q == pl0sm_pkg::OPR_DIV || m_q == pl0sm_pkg::OPR_MOD);
  assign is_sio   = (op_q >= pl0sm_pkg::OP_SIOA) && (op_q <= pl0sm_pkg::OP_SIOC);
  assign sio_wr   = is_sio && (m_q == pl0sm_pkg::SIO_WRITE);
  assign sio_rd   = is_sio && (m_q == pl0sm_pkg::SIO_READ);
  assign sio_halt = is_sio && (m_q == pl0sm_pkg::SIO_HALT);

  // Address arithmetic with range checks
  assign below    = sp_q - AW'(1);
  assign fb_ok    = (fb_q[W-1:AW] == '0);
  assign hop_sum  = {1'b0, fb_q[AW-1:0]} + (AW+1)'(1);
  assign hop_oob  = !fb_ok || hop_sum[AW];
  assign lod_sum  = XW'(fb_q[AW-1:0]) + XW'(m_q);
  assign lod_oob  = !fb_ok || (lod_sum[XW-1:AW] != '0);
  assign ret4_sum = {1'b0, below} + (AW+1)'(4);
  assign ret3_sum = {1'b0, below} + (AW+1)'(3);
  assign cal_sum  = {1'b0, sp_q} + (AW+1)'(cal_q) + (AW+1)'(1);
  assign cal_oob  = cal_sum[AW];

  assign need_a = opr_ret || opr_un || opr_bin || (op_q == pl0sm_pkg::OP_LOD)
                  || (op_q == pl0sm_pkg::OP_STO) || (op_q == pl0sm_pkg::OP_JPC) || sio_wr;
  assign need_b = opr_ret || opr_bin;

  always_comb begin
    addr_a = sp_q;
    oob_a  = 1'b0;
    if (opr_ret) begin
      addr_a = ret4_sum[AW-1:0];
      oob_a  = ret4_sum[AW];
    end else if (op_q == pl0sm_pkg::OP_LOD || op_q == pl0sm_pkg::OP_STO) begin
      addr_a = lod_sum[AW-1:0];
      oob_a  = lod_oob;
    end
    // a store reads the value at the top; its address check comes at write-back
    if (op_q == pl0sm_pkg::OP_STO) begin
      addr_a = sp_q;
      oob_a  = 1'b0;
    end
  end

  assign addr_b = opr_ret ? ret3_sum[AW-1:0] : below;
  assign oob_b  = opr_ret && ret3_sum[AW];

  assign halted_now = halt_q || (bp_q == '0);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // RAM write select
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sp_q + AW'(1);
    ram_wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      S_WB: begin
        if (op_q == pl0sm_pkg::OP_LIT) begin
          ram_we    = 1'b1;
          ram_wdata = W'(m_q);
        end else if (op_q == pl0sm_pkg::OP_LOD) begin
          ram_we    = 1'b1;
          ram_wdata = opb_q;
        end else if (sio_rd) begin
          ram_we    = 1'b1;
          ram_wdata = rv_q;
        end else if (opr_un) begin
          ram_we    = 1'b1;
          ram_waddr = sp_q;
          ram_wdata = res_q;
        end else if (opr_bin) begin
          ram_we    = 1'b1;
          ram_waddr = below;
          ram_wdata = res_q;
        end else if (op_q == pl0sm_pkg::OP_STO) begin
          ram_we    = !lod_oob;
          ram_waddr = lod_sum[AW-1:0];
          ram_wdata = opb_q;
        end
      end
      S_CAL: begin
        ram_we    = !cal_oob;
        ram_waddr = cal_sum[AW-1:0];
        unique case (cal_q)
          2'd0:    ram_wdata = '0;
          2'd1:    ram_wdata = fb_q;
          2'd2:    ram_wdata = W'(bp_q);
          default: ram_wdata = W'(pc_q);
        endcase
      end
      default: ram_we = 1'b0;
    endcase
  end

  // RAM read select
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = addr_a;
    unique case (state_q)
      S_HOP: begin
        ram_re    = (hop_q != '0) && !hop_oob;
        ram_raddr = hop_sum[AW-1:0];
      end
      S_RDA: ram_re = need_a && !oob_a;
      S_RDB: begin
        ram_re    = need_b && !oob_b;
        ram_raddr = addr_b;
      end
      default: ram_re = 1'b0;
    endcase
  end

  pl0sm_ram #(
    .WIDTH(W),
    .DEPTH(pl0sm_pkg::STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Arithmetic on the two operands
  logic [W-1:0] alu_res;
  logic         na, nb;
  logic [W-1:0] ma, mb;
  logic [W:0]   dt;
  logic         dge;
  logic [W:0]   dsub;

  assign na = opa_q[W-1];
  assign nb = opb_q[W-1];
  assign ma = na ? (W'(0) - opa_q) : opa_q;
  assign mb = nb ? (W'(0) - opb_q) : opb_q;

  always_comb begin
    unique case (m_q)
      pl0sm_pkg::OPR_NEG: alu_res = W'(0) - opb_q;
      pl0sm_pkg::OPR_ODD: alu_res = W'(opb_q[0]);
      pl0sm_pkg::OPR_ADD: alu_res = opa_q + opb_q;
      pl0sm_pkg::OPR_SUB: alu_res = opa_q - opb_q;
      pl0sm_pkg::OPR_MUL: alu_res = opa_q * opb_q;
      pl0sm_pkg::OPR_EQL: alu_res = W'(opa_q == opb_q);
      pl0sm_pkg::OPR_NEQ: alu_res = W'(opa_q != opb_q);
      pl0sm_pkg::OPR_LSS: alu_res = W'($signed(opa_q) < $signed(opb_q));
      pl0sm_pkg::OPR_LEQ: alu_res = W'(!($signed(opb_q) < $signed(opa_q)));
      pl0sm_pkg::OPR_GTR: alu_res = W'($signed(opb_q) < $signed(opa_q));
      pl0sm_pkg::OPR_GEQ: alu_res = W'(!($signed(opa_q) < $signed(opb_q)));
      default:            alu_res = '0;
    endcase
  end

  // One restoring divide step
  assign dt   = {dr_q, dq_q[W-1]};
  assign dsub = dt - {1'b0, dv_q};
  assign dge  = !dsub[W];

  // Control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      sp_q        <= '0;
      bp_q        <= AW'(1);
      pc_q        <= '0;
      halt_q      <= 1'b0;
      hop_q       <= '0;
      cal_q       <= '0;
      dcnt_q      <= '0;
      err1_q      <= 1'b0;
      err2_q      <= 1'b0;
      wvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // drop a taken result
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(pl0sm_pkg::STACK_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            err1_q   <= 1'b0;
            err2_q   <= 1'b0;
            wvalid_q <= 1'b0;
            hop_q    <= level_i;
            if (halted_now) begin
              state_q <= S_FIN;
            end else begin
              pc_q <= pc_q + PW'(1);
              if (opcode_i == pl0sm_pkg::OP_LOD || opcode_i == pl0sm_pkg::OP_STO
                  || opcode_i == pl0sm_pkg::OP_CAL) begin
                state_q <= S_HOP;
              end else begin
                state_q <= S_RDA;
              end
            end
          end
        end
        S_HOP: begin
          if (hop_q == '0) begin
            state_q <= S_RDA;
          end else if (hop_oob) begin
            err2_q <= 1'b1;
            hop_q  <= hop_q - 3'd1;
          end else begin
            state_q <= S_HOPW;
          end
        end
        S_HOPW: begin
          hop_q   <= hop_q - 3'd1;
          state_q <= S_HOP;
        end
        S_RDA: begin
          if (need_a && oob_a) begin
            err2_q <= 1'b1;
          end
          state_q <= S_RDB;
        end
        S_RDB: begin
          if (need_b && oob_b) begin
            err2_q <= 1'b1;
          end
          state_q <= S_RDC;
        end
        S_RDC: state_q <= S_EXE;
        S_EXE: begin
          dcnt_q <= '0;
          if (opr_dm && opb_q == '0) begin
            err1_q  <= 1'b1;
            state_q <= S_WB;
          end else if (opr_dm) begin
            state_q <= S_DIV;
          end else begin
            state_q <= S_WB;
          end
        end
        S_DIV: begin
          dcnt_q <= dcnt_q + DW'(1);
          if (dcnt_q == DW'(W - 1)) begin
            state_q <= S_DFIX;
          end
        end
        S_DFIX: state_q <= S_WB;
        S_WB: begin
          state_q <= S_FIN;
          priority if (op_q == pl0sm_pkg::OP_LIT || op_q == pl0sm_pkg::OP_LOD || sio_rd) begin
            sp_q <= sp_q + AW'(1);
          end else if (opr_ret) begin
            sp_q <= below;
            pc_q <= opb_q[PW-1:0];
            bp_q <= opa_q[AW-1:0];
          end else if (opr_bin) begin
            sp_q <= below;
          end else if (op_q == pl0sm_pkg::OP_STO) begin
            sp_q <= below;
            if (lod_oob) begin
              err2_q <= 1'b1;
            end
          end else if (op_q == pl0sm_pkg::OP_CAL) begin
            cal_q   <= '0;
            state_q <= S_CAL;
          end else if (op_q == pl0sm_pkg::OP_INC) begin
            sp_q <= sp_q + m_q[AW-1:0];
          end else if (op_q == pl0sm_pkg::OP_JMP) begin
            pc_q <= m_q[PW-1:0];
          end else if (op_q == pl0sm_pkg::OP_JPC) begin
            sp_q <= below;
            if (opb_q == '0) begin
              pc_q <= m_q[PW-1:0];
            end
          end else if (sio_wr) begin
            sp_q     <= below;
            wvalid_q <= 1'b1;
          end else if (sio_halt) begin
            halt_q <= 1'b1;
          end
        end
        S_CAL: begin
          cal_q <= cal_q + 2'd1;
          if (cal_oob) begin
            err2_q <= 1'b1;
          end
          if (cal_q == 2'd3) begin
            bp_q    <= sp_q + AW'(1);
            pc_q    <= m_q[PW-1:0];
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Request, operand and divider datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= opcode_i;
      m_q  <= operand_i;
      rv_q <= W'(read_value_i);
      fb_q <= W'(bp_q);
    end
    if (state_q == S_HOP && hop_q != '0 && hop_oob) begin
      fb_q <= '0;
    end
    if (state_q == S_HOPW) begin
      fb_q <= ram_rdata;
    end
    if (state_q == S_RDB) begin
      opb_q   <= oob_a_q ? '0 : ram_rdata;
    end
    if (state_q == S_RDA) begin
      oob_a_q <= oob_a;
    end
    if (state_q == S_RDB) begin
      oob_b_q <= oob_b;
    end
    if (state_q == S_RDC) begin
      opa_q <= oob_b_q ? '0 : ram_rdata;
    end
    if (state_q == S_EXE) begin
      res_q <= alu_res;
      dq_q  <= ma;
      dr_q  <= '0;
      dv_q  <= mb;
    end
    if (state_q == S_DIV) begin
      dr_q <= dge ? dsub[W-1:0] : dt[W-1:0];
      dq_q <= {dq_q[W-2:0], dge};
    end
    if (state_q == S_DFIX) begin
      if (m_q == pl0sm_pkg::OPR_MOD) begin
        res_q <= na ? (W'(0) - dr_q) : dr_q;
      end else begin
        res_q <= (na != nb) ? (W'(0) - dq_q) : dq_q;
      end
    end
    if (state_q == S_IDLE) begin
      wval_q <= '0;
    end
    if (state_q == S_WB && sio_wr) begin
      wval_q <= opb_q;
    end
    // load the output register
    if (state_q == S_FIN && out_free) begin
      o_pc_q   <= pc_q;
      o_sp_q   <= sp_q;
      o_bp_q   <= bp_q;
      o_wv_q   <= wvalid_q;
      o_wval_q <= wval_q;
      o_halt_q <= halted_now;
      o_st_q   <= err2_q ? pl0sm_pkg::ST_RANGE
                : (err1_q ? pl0sm_pkg::ST_DIVZ : pl0sm_pkg::ST_OK);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_pc_o     = o_pc_q;
  assign stack_top_o   = o_sp_q;
  assign frame_base_o  = o_bp_q;
  assign write_valid_o = o_wv_q;
  assign write_value_o = o_wval_q;
  assign halted_o      = o_halt_q;
  assign status_o      = o_st_q;

endmodule

// ----- rtl/pl0sm_checker.sv -----
// Port-level checks for the PL/0 stack machine step unit, bound to the top.
// Depends on pl0sm_pkg.
module pl0sm_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic [pl0sm_pkg::PC_W-1:0]             next_pc_o,
  input logic                                   write_valid_o,
  input logic signed [pl0sm_pkg::WORD_BITS-1:0] write_value_o,
  input logic [1:0]                             status_o
);

  // A request in flight blocks the next one
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while the previous one was still executing");

  // A write reads the top of stack, which is always in range
  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_valid_o |-> status_o == pl0sm_pkg::ST_OK)
    else $error("write result reports an error status");

  // No write value without a write
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |-> write_value_o == '0)
    else $error("write value set without a write");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(next_pc_o))
    else $error("stalled result dropped or changed");

endmodule

bind pl0_stack_machine_step_unit pl0sm_checker u_pl0sm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .next_pc_o    (next_pc_o),
  .write_valid_o(write_valid_o),
  .write_value_o(write_value_o),
  .status_o     (status_o)
);

// ----- dv/pl0_stack_machine_step_unit_tb.sv -----
// Self-checking bench for the PL/0 stack machine step unit: directed and random
// instruction streams, each result checked against an in-bench machine model.
// Depends on pl0sm_pkg and the RTL of pl0_stack_machine_step_unit.
`timescale 1ns / 100ps

module pl0_stack_machine_step_unit_tb;
  import pl0sm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [ADDR_W-1:0] PTR_TOP = '1;

  typedef struct {
    logic [PC_W-1:0]      pc;
    logic [ADDR_W-1:0]    sp;
    logic [ADDR_W-1:0]    bp;
    logic                 wr_valid;
    logic [WORD_BITS-1:0] wr_value;
    logic                 halted;
    logic [1:0]           status;
  } step_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] opcode = '0;
  logic [LVL_W-1:0] level = '0;
  logic [OPND_W-1:0] operand = '0;
  logic signed [31:0] read_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PC_W-1:0] next_pc;
  logic [ADDR_W-1:0] stack_top;
  logic [ADDR_W-1:0] frame_base;
  logic write_valid;
  logic signed [WORD_BITS-1:0] write_value;
  logic halted;
  logic [1:0] status;

  int tx_idle = 0;
  int rx_idle = 0;
  int fail_cnt = 0;
  int req_cnt = 0;
  int unsigned cycle_cnt = 0;
  step_result_t expected_q[$];

  // Machine model state
  logic [WORD_BITS-1:0] mdl_stack [STACK_DEPTH];
  logic [ADDR_W-1:0] mdl_sp;
  logic [ADDR_W-1:0] mdl_bp;
  logic [PC_W-1:0] mdl_pc;
  logic mdl_halt;
  logic [1:0] mdl_err;

  pl0_stack_machine_step_unit uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .level_i(level), .operand_i(operand), .read_value_i(read_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .next_pc_o(next_pc), .stack_top_o(stack_top), .frame_base_o(frame_base),
    .write_valid_o(write_valid), .write_value_o(write_value),
    .halted_o(halted), .status_o(status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL pl0_stack_machine_step_unit");
      $finish;
    end
  end

  // Stack access; out-of-range indexes read 0, drop writes and flag a range error
  function automatic logic [WORD_BITS-1:0] stack_read(int unsigned idx);
    if (idx >= STACK_DEPTH) begin
      mdl_err = ST_RANGE;
      return '0;
    end
    return mdl_stack[idx];
  endfunction

  function automatic void stack_write(int unsigned idx, logic [WORD_BITS-1:0] v);
    if (idx >= STACK_DEPTH) mdl_err = ST_RANGE;
    else mdl_stack[idx] = v;
  endfunction

  function automatic int unsigned word_to_addr(logic [WORD_BITS-1:0] w);
    if (w[WORD_BITS-1] || w >= STACK_DEPTH) return STACK_DEPTH;
    return w;
  endfunction

  // Walk static links from the current frame
  function automatic logic [WORD_BITS-1:0] frame_of_level(logic [LVL_W-1:0] lvl);
    logic [WORD_BITS-1:0] b;
    b = mdl_bp;
    repeat (lvl) b = stack_read(word_to_addr(b) + 1);
    return b;
  endfunction

  function automatic logic [WORD_BITS-1:0] div_trunc(logic [WORD_BITS-1:0] a,
                                                      logic [WORD_BITS-1:0] b,
                                                      bit want_rem);
    longint sa, sb, ma, mb, r;
    if (b == '0) begin
      if (mdl_err == ST_OK) mdl_err = ST_DIVZ;
      return '0;
    end
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    ma = (sa < 0) ? -sa : sa;
    mb = (sb < 0) ? -sb : sb;
    if (want_rem) begin
      r = ma % mb;
      if (sa < 0) r = -r;
    end else begin
      r = ma / mb;
      if ((sa < 0) != (sb < 0)) r = -r;
    end
    return r[WORD_BITS-1:0];
  endfunction

  function automatic void exec_opr(logic [OPND_W-1:0] m);
    logic [ADDR_W-1:0] below;
    logic [WORD_BITS-1:0] a, b, r, ret, obp;
    below = mdl_sp - 1'b1;
    if (m == OPR_RET) begin
      ret = stack_read(below + 32'd4);
      obp = stack_read(below + 32'd3);
      mdl_sp = below;
      mdl_pc = ret[PC_W-1:0];
      mdl_bp = obp[ADDR_W-1:0];
      return;
    end
    if (m == OPR_NEG) begin
      stack_write(mdl_sp, -stack_read(mdl_sp));
      return;
    end
    if (m == OPR_ODD) begin
      stack_write(mdl_sp, {31'b0, stack_read(mdl_sp) & 32'd1});
      return;
    end
    if (m > OPR_GEQ) return;
    b = stack_read(mdl_sp);
    a = stack_read(below);
    case (m)
      OPR_ADD: r = a + b;
      OPR_SUB: r = a - b;
      OPR_MUL: r = a * b;
      OPR_DIV: r = div_trunc(a, b, 1'b0);
      OPR_MOD: r = div_trunc(a, b, 1'b1);
      OPR_EQL: r = (a == b);
      OPR_NEQ: r = (a != b);
      OPR_LSS: r = ($signed(a) < $signed(b));
      OPR_LEQ: r = !($signed(b) < $signed(a));
      OPR_GTR: r = ($signed(b) < $signed(a));
      default: r = !($signed(a) < $signed(b));
    endcase
    mdl_sp = below;
    stack_write(below, r);
  endfunction

  // Execute one instruction on the model and return what the unit should report
  function automatic step_result_t execute_instr(logic [3:0] op, logic [LVL_W-1:0] lvl,
                                                 logic [OPND_W-1:0] m,
                                                 logic [31:0] rv);
    step_result_t res;
    logic [WORD_BITS-1:0] v;
    logic [ADDR_W-1:0] sp;
    res.wr_valid = 1'b0;
    res.wr_value = '0;
    mdl_err = ST_OK;
    if (!mdl_halt && mdl_bp != 0) begin
      mdl_pc = mdl_pc + 1'b1;
      case (op)
        OP_LIT: begin
          mdl_sp = mdl_sp + 1'b1;
          stack_write(mdl_sp, {16'b0, m});
        end
        OP_OPR: exec_opr(m);
        OP_LOD: begin
          v = stack_read(word_to_addr(frame_of_level(lvl)) + m);
          mdl_sp = mdl_sp + 1'b1;
          stack_write(mdl_sp, v);
        end
        OP_STO: begin
          stack_write(word_to_addr(frame_of_level(lvl)) + m, stack_read(mdl_sp));
          mdl_sp = mdl_sp - 1'b1;
        end
        OP_CAL: begin
          sp = mdl_sp;
          stack_write(sp + 32'd1, '0);
          stack_write(sp + 32'd2, frame_of_level(lvl));
          stack_write(sp + 32'd3, mdl_bp);
          stack_write(sp + 32'd4, mdl_pc);
          mdl_bp = mdl_sp + 1'b1;
          mdl_pc = m[PC_W-1:0];
        end
        OP_INC: mdl_sp = mdl_sp + m[ADDR_W-1:0];
        OP_JMP: mdl_pc = m[PC_W-1:0];
        OP_JPC: begin
          if (stack_read(mdl_sp) == '0) mdl_pc = m[PC_W-1:0];
          mdl_sp = mdl_sp - 1'b1;
        end
        default: begin
          if (op >= OP_SIOA && op <= OP_SIOC) begin
            if (m == SIO_WRITE) begin
              res.wr_value = stack_read(mdl_sp);
              res.wr_valid = 1'b1;
              mdl_sp = mdl_sp - 1'b1;
            end else if (m == SIO_READ) begin
              mdl_sp = mdl_sp + 1'b1;
              stack_write(mdl_sp, rv);
            end else if (m == SIO_HALT) begin
              mdl_halt = 1'b1;
            end
          end
        end
      endcase
    end
    res.pc = mdl_pc;
    res.sp = mdl_sp;
    res.bp = mdl_bp;
    res.halted = mdl_halt || (mdl_bp == 0);
    res.status = mdl_err;
    return res;
  endfunction

  // Present one request, hold it until accepted, then record its expected result
  task automatic send_request(logic [3:0] op, logic [LVL_W-1:0] lvl,
                              logic [OPND_W-1:0] m, logic [31:0] rv);
    int gap;
    bit taken;
    gap = 0;
    taken = 1'b0;
    while (gap < 30 && $urandom_range(99) < tx_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    level <= lvl;
    operand <= m;
    read_value <= rv;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    expected_q.push_back(execute_instr(op, lvl, m, rv));
    req_cnt++;
  endtask

  // Send, but turn a halt into a read and drop a call or return that would stop the machine before the final test
  task automatic issue(logic [3:0] op, logic [LVL_W-1:0] lvl,
                       logic [OPND_W-1:0] m, logic [31:0] rv);
    int unsigned idx;
    logic [ADDR_W-1:0] nbp;
    if (op >= OP_SIOA && op <= OP_SIOC && m == SIO_HALT) m = SIO_READ;
    if (op == OP_CAL && mdl_sp == PTR_TOP) return;
    if (op == OP_OPR && m == OPR_RET) begin
      idx = (mdl_sp - 1'b1) & PTR_TOP;
      idx = idx + 3;
      nbp = (idx < STACK_DEPTH) ? mdl_stack[idx][ADDR_W-1:0] : '0;
      if (nbp == 0) return;
    end
    send_request(op, lvl, m, rv);
  endtask

  function automatic logic [3:0] sio_opcode();
    return OP_SIOA + 4'($urandom_range(OP_SIOC - OP_SIOA));
  endfunction

  // Drop valid and wait for every outstanding result plus the pipeline tail
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Receiver: randomise stall, check every accepted result
  initial begin
    step_result_t exp_r;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_cnt++;
        end else begin
          exp_r = expected_q.pop_front();
          if (next_pc !== exp_r.pc) begin
            $error("next_pc: expected %0d, got %0d", exp_r.pc, next_pc);
            fail_cnt++;
          end
          if (stack_top !== exp_r.sp) begin
            $error("stack_top: expected %0d, got %0d", exp_r.sp, stack_top);
            fail_cnt++;
          end
          if (frame_base !== exp_r.bp) begin
            $error("frame_base: expected %0d, got %0d", exp_r.bp, frame_base);
            fail_cnt++;
          end
          if (write_valid !== exp_r.wr_valid) begin
            $error("write_valid: expected %0d, got %0d", exp_r.wr_valid, write_valid);
            fail_cnt++;
          end
          if (write_value !== exp_r.wr_value) begin
            $error("write_value: expected %0d, got %0d",
                   $signed(exp_r.wr_value), write_value);
            fail_cnt++;
          end
          if (halted !== exp_r.halted) begin
            $error("halted: expected %0d, got %0d", exp_r.halted, halted);
            fail_cnt++;
          end
          if (status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status);
            fail_cnt++;
          end
        end
      end
      @(posedge clk);
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  // Literals, reads, writes and ignored codes
  task automatic test_literals_io();
    issue(OP_LIT, 3'd7, 16'd0, '0);
    issue(OP_LIT, 3'd0, 16'hFFFF, 32'hFFFF_FFFF);
    issue(OP_SIOC, 3'd0, SIO_WRITE, '0);
    issue(OP_SIOA, 3'd0, SIO_WRITE, '0);
    issue(OP_SIOA, 3'd5, SIO_READ, 32'h7FFF_FFFF);
    issue(OP_SIOC, 3'd2, SIO_READ, 32'h8000_0000);
    issue(OP_SIOA, 3'd0, SIO_WRITE, '0);
    issue(OP_SIOA, 3'd0, 16'd0, '1);
    issue(OP_SIOC, 3'd0, 16'hFFFF, '0);
    issue(4'd0, 3'd7, 16'hFFFF, '1);
  endtask

  // Chain every arithmetic and relational operation through one stack slot
  task automatic test_operations();
    logic [OPND_W-1:0] op_num;
    issue(OP_SIOA, 3'd0, SIO_READ, $urandom);
    for (op_num = OPR_NEG; op_num <= OPR_GEQ; op_num++) begin
      if (op_num != OPR_NEG && op_num != OPR_ODD)
        issue(OP_SIOA, 3'd0, SIO_READ, $urandom);
      issue(OP_OPR, 3'd0, op_num, '0);
    end
    issue(OP_SIOA, 3'd0, SIO_WRITE, '0);
  endtask

  // Divide by zero, overflowing quotient, negative odd, range errors, frames
  task automatic test_special_cases();
    issue(OP_SIOA, 3'd0, SIO_READ, 32'h8000_0000);
    issue(OP_SIOA, 3'd0, SIO_READ, 32'hFFFF_FFFF);
    issue(OP_OPR, 3'd0, OPR_DIV, '0);
    issue(OP_SIOA, 3'd0, SIO_READ, -32'sd7);
    issue(OP_LIT, 3'd0, 16'd0, '0);
    issue(OP_OPR, 3'd0, OPR_MOD, '0);
    issue(OP_SIOA, 3'd0, SIO_READ, -32'sd3);
    issue(OP_OPR, 3'd0, OPR_ODD, '0);
    issue(OP_LOD, 3'd0, 16'hFFFF, '0);
    issue(OP_STO, 3'd7, 16'd3, '0);
    issue(OP_CAL, 3'd7, 16'hFFFF, '0);
    issue(OP_INC, 3'd0, 16'd4, '0);
    issue(OP_OPR, 3'd0, 16'd14, '0);
    issue(OP_OPR, 3'd0, 16'hFFFF, '0);
    issue(OP_JPC, 3'd0, 16'd17, '0);
    issue(OP_JMP, 3'd0, 16'hFFFF, '0);
    issue(OP_INC, 3'd0, 16'hFFFC, '0);
    issue(OP_OPR, 3'd0, OPR_RET, '0);
  endtask

  // Random mix of expressions, procedure bodies and noise
  task automatic test_random(int n);
    int stop_at;
    stop_at = req_cnt + n;
    while (req_cnt < stop_at) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          if ($urandom_range(1)) issue(OP_LIT, 3'($urandom), 16'($urandom), $urandom);
          else issue(sio_opcode(), 3'($urandom), SIO_READ, $urandom);
          if ($urandom_range(7) == 0) issue(OP_LIT, 3'($urandom), 16'd0, $urandom);
          else if ($urandom_range(1)) issue(OP_SIOA, 3'd0, SIO_READ, $urandom);
          else issue(OP_SIOA, 3'd0, SIO_READ, $urandom_range(9) - 5);
          issue(OP_OPR, 3'($urandom), 16'($urandom_range(OPR_NEG, OPR_GEQ)), $urandom);
          case ($urandom_range(2))
            0: issue(sio_opcode(), 3'($urandom), SIO_WRITE, $urandom);
            1: issue(OP_STO, 3'($urandom_range(2)), 16'($urandom_range(7)), $urandom);
            default: issue(OP_JPC, 3'($urandom), 16'($urandom), $urandom);
          endcase
        end
        4, 5, 6: begin
          issue(OP_CAL, 3'($urandom_range(3)), 16'($urandom), $urandom);
          issue(OP_INC, 3'($urandom), 16'(4 + $urandom_range(4)), $urandom);
          repeat ($urandom_range(1, 4)) begin
            issue(OP_LOD, 3'($urandom_range(3)), 16'($urandom_range(7)), $urandom);
            issue(OP_LIT, 3'd0, 16'($urandom), $urandom);
            issue(OP_OPR, 3'd0, 16'($urandom_range(OPR_ADD, OPR_MUL)), $urandom);
            issue(OP_STO, 3'($urandom_range(3)), 16'($urandom_range(7)), $urandom);
          end
          if ($urandom_range(1)) issue(sio_opcode(), 3'd0, SIO_WRITE, $urandom);
          issue(OP_OPR, 3'($urandom), OPR_RET, $urandom);
        end
        7: issue(OP_JMP, 3'($urandom), 16'($urandom), $urandom);
        default: issue(4'($urandom_range(11)), 3'($urandom), 16'($urandom), $urandom);
      endcase
    end
  endtask

  // Stop the machine, by halt or by returning to base zero, then check it stays put
  task automatic test_halt();
    if ($urandom_range(1)) begin
      send_request(OP_SIOA + 4'($urandom_range(OP_SIOC - OP_SIOA)), 3'd0, SIO_HALT, '0);
    end else begin
      repeat (4) send_request(OP_LIT, 3'd0, 16'd0, '0);
      send_request(OP_INC, 3'd0, 16'hFFFD, '0);
      send_request(OP_OPR, 3'd0, OPR_RET, '0);
    end
    send_request(OP_LIT, 3'd0, 16'd9, '0);
    send_request(OP_SIOA, 3'd0, SIO_WRITE, '0);
    send_request(OP_SIOA, 3'd0, SIO_HALT, '0);
  endtask

  initial begin
    foreach (mdl_stack[i]) mdl_stack[i] = '0;
    mdl_sp = '0;
    mdl_bp = 1;
    mdl_pc = '0;
    mdl_halt = 1'b0;
    mdl_err = ST_OK;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle = 22;
    rx_idle = 80;
    test_literals_io();
    test_operations();
    test_special_cases();
    test_random(330);
    tx_idle = 80;
    rx_idle = 22;
    test_random(330);
    tx_idle = 0;
    rx_idle = 0;
    test_random(340);
    test_halt();
    drain();

    if (fail_cnt == 0) begin
      $display("PASS pl0_stack_machine_step_unit");
    end else begin
      $display("FAIL pl0_stack_machine_step_unit");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pl0sm_pkg.sv
rtl/pl0sm_ram.sv
rtl/pl0_stack_machine_step_unit.sv
rtl/pl0sm_checker.sv
dv/pl0_stack_machine_step_unit_tb.sv
